// ===== hw/rtl/ult_pkg.sv =====
// Shared codes and result layout for the unsorted list table.
package ult_pkg;

  localparam int FuncW   = 3;
  localparam int StatusW = 2;
  localparam int OutValW = 32;
  localparam int OutCntW = 7;
  localparam int InDataW = 40;
  localparam int OutDataW = 48;

  localparam logic [FuncW-1:0] OP_INSERT = 3'd0;
  localparam logic [FuncW-1:0] OP_DELETE = 3'd1;
  localparam logic [FuncW-1:0] OP_LOOKUP = 3'd2;
  localparam logic [FuncW-1:0] OP_EMPTY  = 3'd3;
  localparam logic [FuncW-1:0] OP_REWIND = 3'd4;
  localparam logic [FuncW-1:0] OP_READ   = 3'd5;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatusW-1:0] ST_ABSENT   = 2'd2;
  localparam logic [StatusW-1:0] ST_PAST_END = 2'd3;

  // Packed result, found in the lowest bit.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               is_full;
    logic [OutCntW-1:0] count;
    logic [OutValW-1:0] read_value;
    logic               found;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage

// ===== hw/rtl/ult_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ult_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/unsorted_list_table_core.sv =====
// Unsorted list table: insert, delete, lookup, empty, rewind and read-next over a RAM.
// Insert, empty, rewind and unused codes go from S_EXEC straight to S_RESULT; read next passes through S_RDATA.
// Lookup and delete scan the RAM one entry per cycle; a delete that hits then passes through S_MOVE.
// One request in flight at a time; the next is taken once the result is in the output register.
// Reset (rst, synchronous): count and read cursor zero, no result pending; RAM contents kept.
module unsorted_list_table_core #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ult_pkg::InDataW-1:0]  s_tdata,  // func[2:0], value[34:3], zero pad
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ult_pkg::OutDataW-1:0] m_tdata   // found, read_value, count, is_full, status, pad
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_RDATA  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]                   state, state_next;
  logic [ult_pkg::FuncW-1:0]    op;
  logic [VALUE_WIDTH-1:0]       key;
  logic [CW-1:0]                entry_count, entry_count_next;
  logic [CW-1:0]                cursor, cursor_next;
  logic [CW-1:0]                scan_idx, scan_idx_next;
  logic                         cmp_vld, cmp_vld_next;
  logic [CW-1:0]                cmp_idx, cmp_idx_next;
  logic [AW-1:0]                hit_idx, hit_idx_next;
  logic                         res_found, res_found_next;
  logic [VALUE_WIDTH-1:0]       res_rd, res_rd_next;
  logic [ult_pkg::StatusW-1:0]  res_status, res_status_next;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [VALUE_WIDTH-1:0]       ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [VALUE_WIDTH-1:0]       ram_rdata;

  logic                         out_free;
  ult_pkg::result_t             res;

  ult_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    cursor_next      = cursor;
    scan_idx_next    = scan_idx;
    cmp_vld_next     = 1'b0;
    cmp_idx_next     = cmp_idx;
    hit_idx_next     = hit_idx;
    res_found_next   = res_found;
    res_rd_next      = res_rd;
    res_status_next  = res_status;
    ram_we           = 1'b0;
    ram_waddr        = hit_idx;
    ram_wdata        = ram_rdata;
    ram_raddr        = scan_idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_found_next  = 1'b0;
        res_rd_next     = '0;
        res_status_next = ult_pkg::ST_OK;
        scan_idx_next   = '0;
        state_next      = S_RESULT;
        case (op)
          ult_pkg::OP_INSERT: begin
            if (entry_count == CW'(DEPTH)) begin
              res_status_next = ult_pkg::ST_FULL;
            end else begin
              ram_we           = 1'b1;
              ram_waddr        = entry_count[AW-1:0];
              ram_wdata        = key;
              entry_count_next = entry_count + 1'b1;
            end
          end
          ult_pkg::OP_DELETE, ult_pkg::OP_LOOKUP: begin
            if (entry_count == '0) begin
              if (op == ult_pkg::OP_DELETE) begin
                res_status_next = ult_pkg::ST_ABSENT;
              end
            end else begin
              state_next = S_SCAN;
            end
          end
          ult_pkg::OP_EMPTY: begin
            entry_count_next = '0;
          end
          ult_pkg::OP_REWIND: begin
            cursor_next = '0;
          end
          ult_pkg::OP_READ: begin
            if (cursor < entry_count) begin
              ram_raddr   = cursor[AW-1:0];
              cursor_next = cursor + 1'b1;
              state_next  = S_RDATA;
            end else begin
              res_status_next = ult_pkg::ST_PAST_END;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (scan_idx < entry_count) begin
          cmp_vld_next  = 1'b1;
          cmp_idx_next  = scan_idx;
          scan_idx_next = scan_idx + 1'b1;
        end
        if (cmp_vld && ram_rdata == key) begin
          cmp_vld_next   = 1'b0;
          res_found_next = 1'b1;
          res_rd_next    = ram_rdata;
          if (op == ult_pkg::OP_DELETE) begin
            hit_idx_next = cmp_idx[AW-1:0];
            ram_raddr    = AW'(entry_count - 1'b1);
            state_next   = S_MOVE;
          end else begin
            state_next = S_RESULT;
          end
        end else if (cmp_vld && cmp_idx == CW'(entry_count - 1'b1)) begin
          cmp_vld_next = 1'b0;
          if (op == ult_pkg::OP_DELETE) begin
            res_status_next = ult_pkg::ST_ABSENT;
          end
          state_next = S_RESULT;
        end
      end
      S_MOVE: begin
        // last entry fills the hole
        ram_we           = 1'b1;
        ram_waddr        = hit_idx;
        ram_wdata        = ram_rdata;
        entry_count_next = entry_count - 1'b1;
        state_next       = S_RESULT;
      end
      S_RDATA: begin
        res_rd_next = ram_rdata;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.found      = res_found;
    res.read_value = ult_pkg::OutValW'(res_rd);
    res.count      = ult_pkg::OutCntW'(entry_count);
    res.is_full    = (entry_count == CW'(DEPTH));
    res.status     = res_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      cursor      <= '0;
      cmp_vld     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      cursor      <= cursor_next;
      cmp_vld     <= cmp_vld_next;
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op  <= s_tdata[ult_pkg::FuncW-1:0];
      key <= VALUE_WIDTH'(s_tdata[ult_pkg::FuncW +: ult_pkg::OutValW]);
    end
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    hit_idx    <= hit_idx_next;
    res_found  <= res_found_next;
    res_rd     <= res_rd_next;
    res_status <= res_status_next;
    if (state == S_RESULT && out_free) begin
      m_tdata <= {(ult_pkg::OutDataW - ult_pkg::ResultW)'(0), res};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[42:41] == ult_pkg::ST_FULL) |-> m_tdata[40])
    else $error("insert dropped while table not full");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[42:41] == ult_pkg::ST_OK))
    else $error("found result with error status");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_MOVE) |=> $stable(cursor))
    else $error("cursor moved during search");

endmodule
